/* rtl/core/sha1_message_hasher_defines.svh */
// Assertion macros for the SHA-1 message hasher.
`ifndef SHA1_MESSAGE_HASHER_DEFINES_SVH
`define SHA1_MESSAGE_HASHER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define SHA1MH_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sha1 hasher check failed");
// Next-cycle implication, disabled during reset.
`define SHA1MH_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sha1 hasher check failed");
`else
`define SHA1MH_ASSERT_NOW(label, clk, rst, pre, post)
`define SHA1MH_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

/* rtl/core/sha1mh_pkg.sv */
package sha1mh_pkg;

  // Byte source for one absorb step
  typedef enum logic [1:0] {
    SRC_INPUT = 2'd0,
    SRC_MARK  = 2'd1,
    SRC_ZERO  = 2'd2,
    SRC_LEN   = 2'd3
  } byte_src_t;

  // Controller to datapath
  typedef struct packed {
    logic      absorb;
    byte_src_t src;
    logic      load;
    logic      round;
    logic      add;
    logic      init;
    logic [2:0] word_sel;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic block_full;
    logic last_round;
    logic at_len_pos;
  } sts_t;

  localparam logic [4:0][31:0] INIT_CHAIN = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam logic [6:0] LAST_ROUND  = 7'd79;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam logic [2:0] LAST_WORD   = 3'd4;
  localparam logic [3:0] LEN_BYTES   = 4'd8;

endpackage

/* rtl/core/sha1mh_ctrl.sv */
module sha1mh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tlast,
  input  logic              s_tuser,
  output logic              s_tready,
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic              m_tlast,
  output logic [2:0]        word_index,
  output sha1mh_pkg::cmd_t  cmd,
  input  sha1mh_pkg::sts_t  sts
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_LOAD  = 6'b000100,
    S_ROUND = 6'b001000,
    S_ADD   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic       fin, fin_next;
  logic       mark_done, mark_done_next;
  logic [3:0] len_cnt, len_cnt_next;
  logic [2:0] word_index_next;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tlast  = (word_index == sha1mh_pkg::LAST_WORD);

  // Sequencing: take item, pad, compress, emit digest
  always_comb begin
    state_next      = state;
    fin_next        = fin;
    mark_done_next  = mark_done;
    len_cnt_next    = len_cnt;
    word_index_next = word_index;
    cmd             = '0;
    cmd.src         = sha1mh_pkg::SRC_INPUT;
    cmd.word_sel    = word_index;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.absorb = !s_tuser;
          fin_next   = s_tlast;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.block_full) begin
          state_next = S_LOAD;
        end else if (!fin) begin
          state_next = S_IDLE;
        end else if (!mark_done) begin
          cmd.absorb     = 1'b1;
          cmd.src        = sha1mh_pkg::SRC_MARK;
          mark_done_next = 1'b1;
        end else if (len_cnt == 4'd0 && !sts.at_len_pos) begin
          cmd.absorb = 1'b1;
          cmd.src    = sha1mh_pkg::SRC_ZERO;
        end else if (len_cnt != sha1mh_pkg::LEN_BYTES) begin
          cmd.absorb   = 1'b1;
          cmd.src      = sha1mh_pkg::SRC_LEN;
          len_cnt_next = len_cnt + 4'd1;
        end else begin
          state_next = S_OUT;
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (sts.last_round) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_CHECK;
      end
      S_OUT: begin
        if (m_tready) begin
          if (word_index == sha1mh_pkg::LAST_WORD) begin
            cmd.init        = 1'b1;
            word_index_next = 3'd0;
            fin_next        = 1'b0;
            mark_done_next  = 1'b0;
            len_cnt_next    = 4'd0;
            state_next      = S_IDLE;
          end else begin
            word_index_next = word_index + 3'd1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fin        <= 1'b0;
      mark_done  <= 1'b0;
      len_cnt    <= 4'd0;
      word_index <= 3'd0;
    end else begin
      state      <= state_next;
      fin        <= fin_next;
      mark_done  <= mark_done_next;
      len_cnt    <= len_cnt_next;
      word_index <= word_index_next;
    end
  end

endmodule

/* rtl/core/sha1mh_dp.sv */
module sha1mh_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        data_byte,
  input  sha1mh_pkg::cmd_t  cmd,
  output sha1mh_pkg::sts_t  sts,
  output logic [31:0]       digest_word
);

  logic [4:0][31:0]  chain;
  logic [15:0][31:0] win;        // W[t-16] at 0 .. W[t-1] at 15
  logic [31:0]       wa, wb, wc, wd, we;
  logic [31:0]       wasm;
  logic [60:0]       byte_count;
  logic [6:0]        rc;
  logic [63:0]       len_bits;
  logic              block_full;

  logic [7:0]  abyte;
  logic [31:0] wasm_new;
  logic [60:0] cnt_inc;
  logic        word_done;
  logic [31:0] mix, w_cur, f, k, t;

  // Byte source select
  always_comb begin
    unique case (cmd.src)
      sha1mh_pkg::SRC_INPUT: abyte = data_byte;
      sha1mh_pkg::SRC_MARK:  abyte = sha1mh_pkg::PAD_MARK;
      sha1mh_pkg::SRC_ZERO:  abyte = 8'h00;
      sha1mh_pkg::SRC_LEN:   abyte = len_bits[63:56];
      default:               abyte = 8'h00;
    endcase
  end

  assign wasm_new  = {wasm[23:0], abyte};
  assign cnt_inc   = byte_count + 61'd1;
  assign word_done = (cnt_inc[1:0] == 2'b00);

  // Message schedule: first 16 rounds recirculate, later ones expand
  assign mix   = win[13] ^ win[8] ^ win[2] ^ win[0];
  assign w_cur = (rc < 7'd16) ? win[0] : {mix[30:0], mix[31]};

  // Round function and constant
  always_comb begin
    if (rc < 7'd20) begin
      f = (wb & wc) | (~wb & wd);
      k = sha1mh_pkg::K_R0;
    end else if (rc < 7'd40) begin
      f = wb ^ wc ^ wd;
      k = sha1mh_pkg::K_R1;
    end else if (rc < 7'd60) begin
      f = (wb & wc) | (wb & wd) | (wc & wd);
      k = sha1mh_pkg::K_R2;
    end else begin
      f = wb ^ wc ^ wd;
      k = sha1mh_pkg::K_R3;
    end
  end

  assign t = {wa[26:0], wa[31:27]} + f + we + k + w_cur;

  assign sts.block_full = block_full;
  assign sts.last_round = (rc == sha1mh_pkg::LAST_ROUND);
  assign sts.at_len_pos = (byte_count[5:0] == sha1mh_pkg::LEN_POS);

  assign digest_word = chain[cmd.word_sel];

  // Chain value, counters and assembler
  always_ff @(posedge clk) begin
    if (rst) begin
      chain      <= sha1mh_pkg::INIT_CHAIN;
      wasm       <= 32'd0;
      byte_count <= 61'd0;
      rc         <= 7'd0;
      block_full <= 1'b0;
    end else begin
      if (cmd.init) begin
        chain      <= sha1mh_pkg::INIT_CHAIN;
        wasm       <= 32'd0;
        byte_count <= 61'd0;
      end
      if (cmd.absorb) begin
        byte_count <= cnt_inc;
        if (word_done) begin
          wasm <= 32'd0;
          if (cnt_inc[5:0] == 6'd0) begin
            block_full <= 1'b1;
          end
        end else begin
          wasm <= wasm_new;
        end
      end
      if (cmd.load) begin
        rc         <= 7'd0;
        block_full <= 1'b0;
      end
      if (cmd.round) begin
        rc <= rc + 7'd1;
      end
      if (cmd.add) begin
        chain[0] <= chain[0] + wa;
        chain[1] <= chain[1] + wb;
        chain[2] <= chain[2] + wc;
        chain[3] <= chain[3] + wd;
        chain[4] <= chain[4] + we;
      end
    end
  end

  // Schedule window, working variables, length shifter
  always_ff @(posedge clk) begin
    if (cmd.absorb && word_done) begin
      win <= {wasm_new, win[15:1]};
    end else if (cmd.round) begin
      win <= {w_cur, win[15:1]};
    end
    if (cmd.absorb && cmd.src == sha1mh_pkg::SRC_MARK) begin
      len_bits <= {byte_count, 3'b000};
    end else if (cmd.absorb && cmd.src == sha1mh_pkg::SRC_LEN) begin
      len_bits <= {len_bits[55:0], 8'h00};
    end
    if (cmd.load) begin
      wa <= chain[0];
      wb <= chain[1];
      wc <= chain[2];
      wd <= chain[3];
      we <= chain[4];
    end else if (cmd.round) begin
      we <= wd;
      wd <= wc;
      wc <= {wb[1:0], wb[31:2]};
      wb <= wa;
      wa <= t;
    end
  end

endmodule

/* rtl/core/sha1_message_hasher.sv */
// Channel  | Dir | Group            | Content
// ---------+-----+------------------+---------------------------------------------
// s_*      | in  | tvalid/tready    | one message byte per item, tlast ends message
// m_*      | out | tvalid/tready    | five digest words per message, tlast on word 4
//
// Each message byte is accepted, then passes the absorb check. Every 64th byte
// adds a load, 80 rounds through one shared round unit, a chain add and a recheck.
// The final item adds padding at one byte per cycle (9 to 72 bytes), paused while
// a block is compressed, plus one or two compressions; then the digest words leave
// one per accepted item. s_tready is high only while no item is in progress. Reset
// is synchronous and restores the initial chain value; no clearing pass is needed.
`include "sha1_message_hasher_defines.svh"

module sha1_message_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // final_item
  input  logic        s_tuser,   // [0] no_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic        m_tlast,   // last_word
  output logic [2:0]  m_tuser    // [2:0] word_index
);

  sha1mh_pkg::cmd_t cmd;
  sha1mh_pkg::sts_t sts;

  sha1mh_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tlast    (s_tlast),
    .s_tuser    (s_tuser),
    .s_tready   (s_tready),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .m_tlast    (m_tlast),
    .word_index (m_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

  sha1mh_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (s_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .digest_word (m_tdata)
  );

  // Never take a new item while a digest is being delivered
  `SHA1MH_ASSERT_NOW(a_ready_vs_out, clk, rst, s_tready, !m_tvalid)
  // Rounds and byte absorption never overlap
  `SHA1MH_ASSERT_NOW(a_round_no_absorb, clk, rst, cmd.round, !cmd.absorb)
  // Digest word index stays in range while presented
  `SHA1MH_ASSERT_NOW(a_index_range, clk, rst, m_tvalid, m_tuser <= 3'd4)
  // After the last digest word the block is ready for a new message
  `SHA1MH_ASSERT_NEXT(a_restart, clk, rst, m_tvalid && m_tready && m_tlast, s_tready)

endmodule

/* test/sha1_message_hasher_tb.sv */
module sha1_message_hasher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RUN_LIMIT   = 100000;
  localparam int          DRAIN_WAIT  = 200;
  localparam int          HOLD_CYCLES = 500;
  localparam int          IDLE_PCT    = 18;
  localparam int          ERR_SHOW    = 10;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam logic [5:0]  LEN_SLOT    = 6'd56;
  localparam int          NUM_WORDS   = 5;
  localparam logic [2:0]  LAST_IDX    = 3'd4;

  localparam logic [31:0] H0_INIT [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [31:0] K_00_19 = 32'h5A827999;
  localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
  localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
  localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       nob;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        lst;
  } digest_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic        s_tlast = 1'b0;    // final_item
  logic        s_tuser = 1'b0;    // [0] no_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // [31:0] digest_word
  logic        m_tlast;           // last_word
  logic [2:0]  m_tuser;           // [2:0] word_index

  sha1_message_hasher uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  msg_item_t    pending_bytes[$];
  digest_item_t digest_due[$];
  int           err_cnt = 0;
  int           cyc = 0;
  bit           byte_taken = 1'b0;
  int           hold_left = 0;
  bit           hold_done = 1'b0;
  int           words_taken = 0;

  // SHA-1 state mirrored in the testbench
  logic [31:0] hash_h [NUM_WORDS];
  logic [31:0] sched_w [16];
  logic [31:0] word_acc;
  logic [60:0] msg_len;

  function automatic void sha_restart();
    for (int i = 0; i < NUM_WORDS; i++) hash_h[i] = H0_INIT[i];
    word_acc = '0;
    msg_len  = '0;
  endfunction

  // 80 rounds over the 16-word window, schedule expanded in place
  function automatic void sha_compress();
    logic [31:0] a, b, c, d, e, f, k, t, w;
    a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3]; e = hash_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        w = sched_w[r];
      end else begin
        w = sched_w[(r + 13) % 16] ^ sched_w[(r + 8) % 16] ^
            sched_w[(r + 2) % 16] ^ sched_w[r % 16];
        w = {w[30:0], w[31]};
        sched_w[r % 16] = w;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_00_19;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_20_39;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_40_59;
      end else begin
        f = b ^ c ^ d;
        k = K_60_79;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d; hash_h[4] += e;
  endfunction

  function automatic void sha_absorb(input logic [7:0] b);
    logic [60:0] prev;
    word_acc = {word_acc[23:0], b};
    msg_len  = msg_len + 61'd1;
    if (msg_len[1:0] == 2'd0) begin
      prev = msg_len - 61'd1;
      sched_w[prev[5:2]] = word_acc;
      word_acc = '0;
      if (msg_len[5:0] == 6'd0) sha_compress();
    end
  endfunction

  // One accepted item; a final one pads, closes the message and queues the digest
  function automatic void sha_take(input msg_item_t it);
    logic [63:0]  bit_len;
    digest_item_t dw;
    if (!it.nob) sha_absorb(it.data);
    if (it.fin) begin
      bit_len = {msg_len, 3'b000};
      sha_absorb(PAD_BYTE);
      while (msg_len[5:0] != LEN_SLOT) sha_absorb(8'h00);
      for (int i = 0; i < 8; i++) sha_absorb(bit_len[63 - 8 * i -: 8]);
      for (int i = 0; i < NUM_WORDS; i++) begin
        dw.word = hash_h[i];
        dw.idx  = 3'(i);
        dw.lst  = (3'(i) == LAST_IDX);
        digest_due.push_back(dw);
      end
      sha_restart();
    end
  endfunction

  function automatic bit want_idle();
    if (cyc >= 1500 && cyc < 3500) return 1'b0;
    return ($urandom_range(99) < IDLE_PCT);
  endfunction

  task automatic note_error(input string msg);
    err_cnt++;
    if (err_cnt <= ERR_SHOW) $display("ERROR @%0d: %s", cyc, msg);
  endtask

  function automatic void push_item(input logic [7:0] data, input logic fin, input logic nob);
    msg_item_t it;
    it.data = data;
    it.fin  = fin;
    it.nob  = nob;
    pending_bytes.push_back(it);
  endfunction

  // A message of len bytes; optionally closed by a byte-less final item.
  // Ignored byte-less items are sprinkled in as noise.
  function automatic void add_msg(input int len, input bit end_empty, input bit noise);
    for (int i = 0; i < len; i++) begin
      if (noise && $urandom_range(99) < 5) push_item(8'($urandom_range(255)), 1'b0, 1'b1);
      push_item(8'($urandom_range(255)), !end_empty && (i == len - 1), 1'b0);
    end
    if (end_empty || len == 0) push_item(8'($urandom_range(255)), 1'b1, 1'b1);
  endfunction

  // Stimulus and end of run
  initial begin
    int n_items;
    int n_msgs;
    int len;
    bit end_empty;
    sha_restart();
    for (int i = 0; i < 16; i++) sched_w[i] = '0;

    // empty message, ignored item, single-byte extremes, "abc" closed byte-less, a two-byte message, one more empty
    push_item(8'hAB, 1'b1, 1'b1);
    push_item(8'hFF, 1'b0, 1'b1);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hFF, 1'b1, 1'b0);
    push_item(8'h61, 1'b0, 1'b0);
    push_item(8'h62, 1'b0, 1'b0);
    push_item(8'h63, 1'b0, 1'b0);
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'hFF, 1'b1, 1'b0);
    push_item(8'h55, 1'b0, 1'b1);
    push_item(8'hAA, 1'b1, 1'b1);

    // random messages, many of them near the 55/56/64-byte boundaries
    n_items = 0;
    n_msgs  = 0;
    while (n_items < 100 || n_msgs < 8) begin
      case ($urandom_range(9))
        0, 1, 2, 3: len = $urandom_range(8);
        4, 5, 6:    len = $urandom_range(66, 50);
        default:    len = $urandom_range(130);
      endcase
      end_empty = ($urandom_range(3) == 0);
      add_msg(len, end_empty, 1'b1);
      n_items += len + ((end_empty || len == 0) ? 1 : 0);
      n_msgs++;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || digest_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_cnt == 0 && digest_due.size() == 0) begin
      $display("sha1_message_hasher_tb passed");
    end else begin
      $display("sha1_message_hasher_tb failed");
    end
    $finish;
  end

  // Cycle count and run limit
  always @(posedge clk) begin
    cyc++;
    if (cyc > RUN_LIMIT) begin
      $display("sha1_message_hasher_tb failed");
      $finish;
    end
  end

  // Input acceptance feeds the predictor
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      sha_take(pending_bytes.pop_front());
      byte_taken = 1'b1;
    end
  end

  // Input driver: hold an offered item until taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !byte_taken) begin
      // keep offering
    end else if (pending_bytes.size() != 0 && !want_idle()) begin
      s_tvalid <= 1'b1;
      s_tdata  <= pending_bytes[0].data;
      s_tlast  <= pending_bytes[0].fin;
      s_tuser  <= pending_bytes[0].nob;
    end else begin
      s_tvalid <= 1'b0;
    end
    byte_taken = 1'b0;
  end

  // Long receiver hold-off, once, in the middle of a digest
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) words_taken++;
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && m_tvalid && words_taken == 7) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
    end
  end

  // Output ready
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (hold_left == 0) && !want_idle();
    end
  end

  // Output checker
  always @(posedge clk) begin
    digest_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (digest_due.size() == 0) begin
        note_error($sformatf("unexpected digest item word %h idx %0d last %b",
                             m_tdata, m_tuser, m_tlast));
      end else begin
        want = digest_due.pop_front();
        if (m_tdata !== want.word || m_tuser !== want.idx || m_tlast !== want.lst) begin
          note_error($sformatf("digest mismatch: exp %h idx %0d last %b, got %h idx %0d last %b",
                               want.word, want.idx, want.lst, m_tdata, m_tuser, m_tlast));
        end
      end
    end
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/sha1mh_pkg.sv
rtl/core/sha1mh_ctrl.sv
rtl/core/sha1mh_dp.sv
rtl/core/sha1_message_hasher.sv
test/sha1_message_hasher_tb.sv
